FILE: hw/rtl/gbs_pkg.sv
// Shared types and constants for the greedy box suppression core.
// No dependencies; every other file refers to this package by scoped names.
package gbs_pkg;

    localparam int COORD_BITS  = 16;
    localparam int MAX_KEPT    = 64;
    localparam int FIELD_W     = 16;
    localparam int THR_W       = 16;
    localparam int KEPT_SLOT_W = 6;
    localparam int SLOT_BITS   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int COUNT_BITS  = $clog2(MAX_KEPT + 1);
    localparam int AREA_W      = 2 * COORD_BITS;
    localparam int UNI_W       = AREA_W + 1;
    localparam int PROD_W      = UNI_W + THR_W;

    localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

    typedef struct packed {
        logic [FIELD_W-1:0] box_left;
        logic [FIELD_W-1:0] box_top;
        logic [FIELD_W-1:0] box_right;
        logic [FIELD_W-1:0] box_bottom;
        logic               group_start;
    } in_t;

    typedef struct packed {
        logic                   keep;
        logic [KEPT_SLOT_W-1:0] kept_slot;
        logic                   store_full;
    } out_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] bottom;
    } box_t;

    typedef struct packed {
        box_t              box;
        logic [AREA_W-1:0] area;
    } entry_t;

    typedef struct packed {
        logic busy;
        logic res_valid;
        logic res_over;
    } ovl_status_t;

    function automatic logic [COORD_BITS-1:0] span(
        input logic [COORD_BITS-1:0] lo,
        input logic [COORD_BITS-1:0] hi
    );
        return (hi > lo) ? (hi - lo) : '0;
    endfunction

endpackage

FILE: hw/rtl/greedy_box_suppression_core.sv
// Greedy non-maximum suppression core: top level, sequencer and output register.
// Depends on gbs_pkg, gbs_box_store and gbs_overlap_unit.
// Boxes of one class come in falling score order, one request at a time; each
// gives one result. The sequencer reads one stored box of the group per cycle
// from the store into a five-stage overlap pipeline, then drains it. Reading
// stops early once a stored box suppresses the current one.
// A new request is taken while the previous result still waits on m_ready.
module greedy_box_suppression_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  gbs_pkg::in_t               s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output gbs_pkg::out_t              m_data,
    input  logic                       cfg_we,
    input  logic [gbs_pkg::THR_W-1:0]  cfg_wdata
);

    localparam int CB = gbs_pkg::COORD_BITS;
    localparam int NB = gbs_pkg::COUNT_BITS;
    localparam int SB = gbs_pkg::SLOT_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AREA,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [gbs_pkg::THR_W-1:0]  thr_reg;
    logic [NB-1:0]              count_reg, count_next;
    logic [NB-1:0]              idx_reg, idx_next;
    logic                       drop_reg, drop_next;
    logic                       issued_reg;
    gbs_pkg::box_t              box_reg, box_next;
    logic [gbs_pkg::AREA_W-1:0] area_reg;
    logic                       m_valid_reg, m_valid_next;
    gbs_pkg::out_t              m_data_reg, m_data_next;

    logic                 accept, rd_en, wr_en, out_free, room;
    gbs_pkg::entry_t      wr_data, rd_data;
    gbs_pkg::ovl_status_t ovl;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign room     = (count_reg < NB'(gbs_pkg::MAX_KEPT));
    assign rd_en    = (state_reg == S_SCAN) && (idx_reg < count_reg) && !drop_reg;
    assign wr_en    = (state_reg == S_DONE) && out_free && !drop_reg && room;
    assign wr_data.box  = box_reg;
    assign wr_data.area = area_reg;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        box_next     = box_reg;
        drop_next    = drop_reg || (ovl.res_valid && ovl.res_over);
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    box_next.left   = CB'(s_data.box_left);
                    box_next.top    = CB'(s_data.box_top);
                    box_next.right  = CB'(s_data.box_right);
                    box_next.bottom = CB'(s_data.box_bottom);
                    if (s_data.group_start) begin
                        count_next = '0;
                    end
                    state_next = S_AREA;
                end
            end
            S_AREA: begin
                idx_next   = '0;
                drop_next  = 1'b0;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (rd_en) begin
                    idx_next = idx_reg + NB'(1);
                end else begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!ovl.busy && !issued_reg) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.keep       = !drop_reg;
                    m_data_next.kept_slot  = '0;
                    m_data_next.store_full = 1'b0;
                    if (!drop_reg) begin
                        if (room) begin
                            m_data_next.kept_slot = gbs_pkg::KEPT_SLOT_W'(count_reg);
                            count_next = count_reg + NB'(1);
                        end else begin
                            m_data_next.store_full = 1'b1;
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            thr_reg     <= gbs_pkg::THR_RESET;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            drop_reg    <= 1'b0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            issued_reg  <= rd_en;
            m_valid_reg <= m_valid_next;
            drop_reg    <= drop_next;
            idx_reg     <= idx_next;
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
        end
        box_reg    <= box_next;
        m_data_reg <= m_data_next;
        if (state_reg == S_AREA) begin
            area_reg <= gbs_pkg::AREA_W'(gbs_pkg::span(box_reg.left, box_reg.right))
                      * gbs_pkg::AREA_W'(gbs_pkg::span(box_reg.top, box_reg.bottom));
        end
    end

    gbs_box_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[SB-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[SB-1:0]),
        .rd_data (rd_data)
    );

    gbs_overlap_unit u_overlap (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .valid_in (issued_reg),
        .cur_box  (box_reg),
        .cur_area (area_reg),
        .kept     (rd_data),
        .thr      (thr_reg),
        .status   (ovl)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= NB'(gbs_pkg::MAX_KEPT))
        else $error("kept count beyond store depth");

    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> room && !drop_reg)
        else $error("store written while full or for a dropped box");

    a_full_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.store_full) |-> m_data_reg.keep)
        else $error("store_full on a dropped box");

    a_result_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ovl.res_valid |-> (state_reg == S_SCAN || state_reg == S_DRAIN))
        else $error("overlap result outside a scan");

    a_done_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && out_free) |=> (m_valid_reg && state_reg == S_IDLE))
        else $error("finished request not presented");

endmodule

FILE: hw/rtl/gbs_box_store.sv
// Kept-box store: one write port, one registered read port.
// Depends on gbs_pkg for the entry type and depth.
module gbs_box_store (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [gbs_pkg::SLOT_BITS-1:0] wr_addr,
    input  gbs_pkg::entry_t               wr_data,
    input  logic                          rd_en,
    input  logic [gbs_pkg::SLOT_BITS-1:0] rd_addr,
    output gbs_pkg::entry_t               rd_data
);

    gbs_pkg::entry_t mem [gbs_pkg::MAX_KEPT];
    gbs_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/gbs_overlap_unit.sv
// Five-stage overlap pipeline: one stored box per cycle against the current box.
// Tests intersection * 2^16 > threshold * union. Depends on gbs_pkg.
module gbs_overlap_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          valid_in,
    input  gbs_pkg::box_t                 cur_box,
    input  logic [gbs_pkg::AREA_W-1:0]    cur_area,
    input  gbs_pkg::entry_t               kept,
    input  logic [gbs_pkg::THR_W-1:0]     thr,
    output gbs_pkg::ovl_status_t          status
);

    localparam int CB = gbs_pkg::COORD_BITS;
    localparam int AW = gbs_pkg::AREA_W;
    localparam int UW = gbs_pkg::UNI_W;
    localparam int PW = gbs_pkg::PROD_W;

    logic [4:0] v_reg;

    logic [CB-1:0] iw1_reg, ih1_reg;
    logic          pos1_reg, pos2_reg, pos3_reg, pos4_reg, over5_reg;
    logic [AW-1:0] karea1_reg, karea2_reg;
    logic [AW-1:0] inter2_reg, inter3_reg, inter4_reg;
    logic [UW-1:0] uni3_reg;
    logic [PW-1:0] prod4_reg;

    logic [CB-1:0] x_lo, x_hi, y_lo, y_hi, iw, ih;
    logic [PW-1:0] inter_scaled;

    always_comb begin
        x_lo = (cur_box.left  > kept.box.left)   ? cur_box.left   : kept.box.left;
        x_hi = (cur_box.right < kept.box.right)  ? cur_box.right  : kept.box.right;
        y_lo = (cur_box.top   > kept.box.top)    ? cur_box.top    : kept.box.top;
        y_hi = (cur_box.bottom < kept.box.bottom) ? cur_box.bottom : kept.box.bottom;
        iw   = gbs_pkg::span(x_lo, x_hi);
        ih   = gbs_pkg::span(y_lo, y_hi);
        inter_scaled = PW'({inter4_reg, {gbs_pkg::THR_W{1'b0}}});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= {v_reg[3:0], valid_in};
        end
        // stage 1: overlap extents
        iw1_reg    <= iw;
        ih1_reg    <= ih;
        pos1_reg   <= (iw != '0) && (ih != '0);
        karea1_reg <= kept.area;
        // stage 2: intersection area
        inter2_reg <= AW'(iw1_reg) * AW'(ih1_reg);
        karea2_reg <= karea1_reg;
        pos2_reg   <= pos1_reg;
        // stage 3: union; intersection never exceeds either area, so no wrap
        uni3_reg   <= UW'(cur_area) + UW'(karea2_reg) - UW'(inter2_reg);
        inter3_reg <= inter2_reg;
        pos3_reg   <= pos2_reg;
        // stage 4: threshold times union
        prod4_reg  <= PW'(thr) * PW'(uni3_reg);
        inter4_reg <= inter3_reg;
        pos4_reg   <= pos3_reg;
        // stage 5: compare
        over5_reg  <= pos4_reg && (inter_scaled > prod4_reg);
    end

    assign status.busy      = |v_reg;
    assign status.res_valid = v_reg[4];
    assign status.res_over  = over5_reg;

endmodule

FILE: dv/greedy_box_suppression_core_tb.sv
// Self-checking testbench for greedy_box_suppression_core: directed boxes, then a full-store group,
// clustered random groups and noise under four phases of idling and stalls and several IoU limits.
// Depends on gbs_pkg and the core RTL only.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT      = 1_500_000;
    localparam int unsigned BOXES_PER_PHASE  = 200;
    localparam int unsigned SETTLE_CYCLES    = 80;
    localparam int unsigned MAX_SHOWN        = 100;

    // Shadow of the suppression state; computes the verdict for every box taken.
    class suppression_scoreboard;
        gbs_pkg::box_t               kept_box  [gbs_pkg::MAX_KEPT];
        logic [gbs_pkg::AREA_W-1:0]  kept_area [gbs_pkg::MAX_KEPT];
        int unsigned                 kept_total;
        logic [gbs_pkg::THR_W-1:0]   iou_limit;
        gbs_pkg::out_t               expected_verdicts[$];
        int unsigned                 mismatches;
        int unsigned                 verdicts_seen;

        function new();
            kept_total    = 0;
            iou_limit     = gbs_pkg::THR_RESET;
            mismatches    = 0;
            verdicts_seen = 0;
        endfunction

        function void set_limit(input logic [gbs_pkg::THR_W-1:0] value);
            iou_limit = value;
        endfunction

        function int unsigned pending();
            return expected_verdicts.size();
        endfunction

        static function logic [gbs_pkg::COORD_BITS-1:0] extent(
            input logic [gbs_pkg::COORD_BITS-1:0] lo,
            input logic [gbs_pkg::COORD_BITS-1:0] hi
        );
            return (hi > lo) ? hi - lo : '0;
        endfunction

        function void note_box(input gbs_pkg::in_t item);
            gbs_pkg::box_t               cand;
            logic [gbs_pkg::AREA_W-1:0]  wx, hy, cand_area, inter;
            logic [gbs_pkg::COORD_BITS-1:0] lo_x, hi_x, lo_y, hi_y, iw, ih;
            logic [63:0]                 union_area, scaled_inter, scaled_union;
            bit                          survives;
            gbs_pkg::out_t               verdict;
            int unsigned                 j;

            if (item.group_start)
                kept_total = 0;
            cand.left   = item.box_left[gbs_pkg::COORD_BITS-1:0];
            cand.top    = item.box_top[gbs_pkg::COORD_BITS-1:0];
            cand.right  = item.box_right[gbs_pkg::COORD_BITS-1:0];
            cand.bottom = item.box_bottom[gbs_pkg::COORD_BITS-1:0];
            wx = gbs_pkg::AREA_W'(extent(cand.left, cand.right));
            hy = gbs_pkg::AREA_W'(extent(cand.top, cand.bottom));
            cand_area = wx * hy;
            survives = 1'b1;

            for (j = 0; j < kept_total; j++) begin
                lo_x = (cand.left > kept_box[j].left) ? cand.left : kept_box[j].left;
                hi_x = (cand.right < kept_box[j].right) ? cand.right : kept_box[j].right;
                lo_y = (cand.top > kept_box[j].top) ? cand.top : kept_box[j].top;
                hi_y = (cand.bottom < kept_box[j].bottom) ? cand.bottom : kept_box[j].bottom;
                iw = extent(lo_x, hi_x);
                ih = extent(lo_y, hi_y);
                if (iw == 0 || ih == 0)
                    continue;
                wx = gbs_pkg::AREA_W'(iw);
                hy = gbs_pkg::AREA_W'(ih);
                inter = wx * hy;
                union_area = 64'(cand_area) + 64'(kept_area[j]) - 64'(inter);
                scaled_inter = 64'(inter) << 16;
                scaled_union = 64'(iou_limit) * union_area;
                // strict compare: an IoU exactly at the limit survives
                if (scaled_inter > scaled_union) begin
                    survives = 1'b0;
                    break;
                end
            end

            verdict = '0;
            verdict.keep = survives;
            if (survives) begin
                if (kept_total < gbs_pkg::MAX_KEPT) begin
                    kept_box[kept_total]  = cand;
                    kept_area[kept_total] = cand_area;
                    verdict.kept_slot = kept_total[gbs_pkg::KEPT_SLOT_W-1:0];
                    kept_total++;
                end else begin
                    verdict.store_full = 1'b1;
                end
            end
            expected_verdicts = {expected_verdicts, verdict};
        endfunction

        task report(input string what);
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("MISMATCH result %0d: %s", verdicts_seen, what);
        endtask

        task check_result(input gbs_pkg::out_t got);
            gbs_pkg::out_t want;
            if (expected_verdicts.size() == 0) begin
                report("result with no box request waiting");
            end else begin
                want = expected_verdicts.pop_front();
                if (got.keep !== want.keep)
                    report($sformatf("keep %0b, expected %0b", got.keep, want.keep));
                if (got.kept_slot !== want.kept_slot)
                    report($sformatf("kept_slot %0d, expected %0d",
                                     got.kept_slot, want.kept_slot));
                if (got.store_full !== want.store_full)
                    report($sformatf("store_full %0b, expected %0b",
                                     got.store_full, want.store_full));
            end
            verdicts_seen++;
        endtask
    endclass

    logic                      aclk;
    logic                      aresetn   = 1'b0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    gbs_pkg::in_t              s_data    = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    gbs_pkg::out_t             m_data;
    logic                      cfg_we    = 1'b0;
    logic [gbs_pkg::THR_W-1:0] cfg_wdata = '0;

    suppression_scoreboard sb;
    gbs_pkg::in_t          box_backlog[$];
    int unsigned           send_idle_pct = 0;
    int unsigned           recv_stall_pct = 0;
    int unsigned           cycle_count = 0;

    greedy_box_suppression_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("greedy_box_suppression_core regression: fail");
            $finish;
        end
    end

    function automatic logic [15:0] fit16(input int v);
        if (v < 0)
            return 16'h0000;
        if (v > 65535)
            return 16'hFFFF;
        return v[15:0];
    endfunction

    function automatic void queue_box(input logic [15:0] l, input logic [15:0] t,
                                      input logic [15:0] r, input logic [15:0] b,
                                      input bit first);
        gbs_pkg::in_t item;
        item.box_left    = l;
        item.box_top     = t;
        item.box_right   = r;
        item.box_bottom  = b;
        item.group_start = first;
        box_backlog = {box_backlog, item};
    endfunction

    // Valid stays up across back-to-back requests; it only drops on an idle cycle or once the backlog is flushed.
    task automatic send_box(input gbs_pkg::in_t item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        sb.note_box(item);
    endtask

    task automatic flush_boxes();
        while (box_backlog.size() != 0)
            send_box(box_backlog.pop_front());
        s_valid <= 1'b0;
    endtask

    task automatic write_threshold(input logic [gbs_pkg::THR_W-1:0] value);
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.set_limit(value);
    endtask

    // 8x8 grid of disjoint boxes fills the store, then one to six extra boxes arrive while it is full.
    task automatic queue_full_group();
        int base_x, base_y, x0, y0, k, extra;
        base_x = int'($urandom_range(0, 16'hBFFF));
        base_y = int'($urandom_range(0, 16'hBFFF));
        for (k = 0; k < gbs_pkg::MAX_KEPT; k++) begin
            x0 = base_x + (k % 8) * 'h800 + int'($urandom_range(0, 'h200));
            y0 = base_y + (k / 8) * 'h800 + int'($urandom_range(0, 'h200));
            queue_box(fit16(x0), fit16(y0), fit16(x0 + int'($urandom_range('h10, 'h500))),
                      fit16(y0 + int'($urandom_range('h10, 'h500))), k == 0);
        end
        extra = int'($urandom_range(1, 6));
        for (k = 0; k < extra; k++) begin
            x0 = base_x + int'($urandom_range(0, 'h3F00));
            y0 = base_y + int'($urandom_range(0, 'h3F00));
            if (k % 2 == 0)
                queue_box(fit16(x0), fit16(y0), fit16(x0), fit16(y0 + 'h40), 1'b0);
            else
                queue_box(fit16(x0), fit16(y0), fit16(x0 + 'h400), fit16(y0 + 'h400), 1'b0);
        end
    endtask

    // Boxes scattered round a centre that now and then jumps, so many pairs overlap heavily.
    task automatic queue_cluster_group();
        int n, k, cx, cy, w, h, spread, x0, y0;
        logic [15:0] l, r;
        n  = int'($urandom_range(1, 24));
        cx = int'($urandom_range(0, 65535));
        cy = int'($urandom_range(0, 65535));
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 5) == 0) begin
                cx = int'($urandom_range(0, 65535));
                cy = int'($urandom_range(0, 65535));
            end
            w = int'($urandom_range(16, 2048));
            h = int'($urandom_range(16, 2048));
            spread = ($urandom_range(0, 2) == 0) ? w : 48;
            x0 = cx - w / 2 + int'($urandom_range(0, 2 * spread)) - spread;
            y0 = cy - h / 2 + int'($urandom_range(0, 2 * spread)) - spread;
            l = fit16(x0);
            r = fit16(x0 + w);
            if ($urandom_range(0, 15) == 0)
                queue_box(r, fit16(y0), l, fit16(y0 + h),
                          k == 0 && $urandom_range(0, 7) != 0);
            else
                queue_box(l, fit16(y0), r, fit16(y0 + h),
                          k == 0 && $urandom_range(0, 7) != 0);
        end
    endtask

    task automatic queue_noise();
        int k, n;
        n = int'($urandom_range(1, 4));
        for (k = 0; k < n; k++)
            queue_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      $urandom_range(0, 3) == 0);
    endtask

    initial begin
        int unsigned phase;
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset limit: full frame, duplicates, degenerate boxes, touching edges
        queue_box(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1);
        queue_box(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0);
        queue_box(16'h0100, 16'h0100, 16'h0100, 16'h0200, 1'b0);
        queue_box(16'h0030, 16'h0020, 16'h0040, 16'h0010, 1'b0);
        queue_box(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        queue_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        queue_box(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
        queue_box(16'h0100, 16'h0100, 16'h0200, 16'h0200, 1'b0);
        queue_box(16'h1000, 16'h1000, 16'h2000, 16'h2000, 1'b1);
        queue_box(16'h2000, 16'h1000, 16'h3000, 16'h2000, 1'b0);
        queue_box(16'h1800, 16'h1000, 16'h2800, 16'h2000, 1'b0);
        queue_box(16'h1100, 16'h1000, 16'h2000, 16'h2000, 1'b0);
        flush_boxes();

        // zero limit: any real overlap suppresses
        write_threshold(16'h0000);
        queue_box(16'h0000, 16'h0000, 16'h0040, 16'h0040, 1'b1);
        queue_box(16'h003F, 16'h003F, 16'h0080, 16'h0080, 1'b0);
        queue_box(16'h0040, 16'h0000, 16'h0080, 16'h0040, 1'b0);
        flush_boxes();

        // top limit: of these boxes only the exact duplicate is suppressed
        write_threshold(16'hFFFF);
        queue_box(16'h0200, 16'h0200, 16'h0400, 16'h0400, 1'b1);
        queue_box(16'h0200, 16'h0200, 16'h0400, 16'h0400, 1'b0);
        queue_box(16'h0200, 16'h0200, 16'h0401, 16'h0400, 1'b0);
        flush_boxes();

        // IoU of exactly one half, at the limit and just above it
        write_threshold(16'h8000);
        queue_box(16'h0000, 16'h0000, 16'h0030, 16'h0010, 1'b1);
        queue_box(16'h0010, 16'h0000, 16'h0040, 16'h0010, 1'b0);
        flush_boxes();
        write_threshold(16'h7FFF);
        queue_box(16'h0000, 16'h0000, 16'h0030, 16'h0010, 1'b1);
        queue_box(16'h0010, 16'h0000, 16'h0040, 16'h0010, 1'b0);
        flush_boxes();

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    write_threshold(16'($urandom_range(16384, 49152)));
                end
                1: begin
                    send_idle_pct = 82;
                    recv_stall_pct = 0;
                    write_threshold(16'hFFFF);
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 82;
                    write_threshold(16'($urandom));
                end
                default: begin
                    send_idle_pct = 13;
                    recv_stall_pct = 13;
                    write_threshold(16'h0000);
                end
            endcase
            queue_full_group();
            while (box_backlog.size() < BOXES_PER_PHASE) begin
                if ($urandom_range(0, 9) < 8)
                    queue_cluster_group();
                else
                    queue_noise();
            end
            flush_boxes();
        end

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("greedy_box_suppression_core regression: pass");
        else
            $display("greedy_box_suppression_core regression: fail");
        $finish;
    end

endmodule

FILE: greedy_box_suppression_core.f
hw/rtl/gbs_pkg.sv
hw/rtl/gbs_box_store.sv
hw/rtl/gbs_overlap_unit.sv
hw/rtl/greedy_box_suppression_core.sv
dv/greedy_box_suppression_core_tb.sv
